[rtl/alist_pkg.sv]
// Package for the array list engine: transaction payloads, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package alist_pkg;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IDX_ZERO  = 2'd0,
    IDX_COUNT = 2'd1,
    IDX_POS   = 2'd2
  } idx_init_e;

  typedef enum logic [1:0] {
    RA_IDX = 2'd0,
    RA_DEC = 2'd1,
    RA_INC = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [31:0] item_value;
    logic [4:0]        position;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] found_index;
    logic [4:0] length;
  } rsp_t;

  typedef struct packed {
    logic      req_load;
    logic      idx_load;
    idx_init_e idx_init;
    logic      idx_inc;
    logic      idx_dec;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_en;
    logic      wr_val;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      res_load;
    status_e   res_status;
    logic      res_found;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic full;
    logic pos_zero;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic idx_next_eq_cnt;
    logic idx_eq_pos_m1;
    logic match;
  } sts_t;

endpackage

[rtl/alist_req_if.sv]
// Request channel of the array list engine: valid, ready and the request payload.
// Depends on alist_pkg.
interface alist_req_if;
  logic             valid;
  logic             ready;
  alist_pkg::req_t  req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

[rtl/alist_rsp_if.sv]
// Response channel of the array list engine: valid, ready and the response payload.
// Depends on alist_pkg.
interface alist_rsp_if;
  logic             valid;
  logic             ready;
  alist_pkg::rsp_t  rsp;

  modport source (output valid, output rsp, input ready);
  modport sink (input valid, input rsp, output ready);
endinterface

[rtl/array_list_engine_top.sv]
// Top level of the array list engine: ordered list of signed 32-bit values with find,
// insert and delete. Depends on alist_pkg, alist_req_if, alist_rsp_if, alist_ctrl, alist_dp.
//
//   channel   dir  modport  payload
//   in_i      in   sink     op, item_value, position
//   out_o     out  source   status, found_index, length
//
// One request is in flight at a time; in_i.ready is high only while the controller is idle.
// Find reads the entries in turn from the first; insert moves entries up one place from the
// end down to the position and writes the value there; delete moves entries down one place
// from the position on; a refused or unused op goes straight to the response.
// Reset clears the entry count; the entry RAM is not cleared. A stalled response holds
// in its register while the next request is accepted and processed.
module array_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  alist_req_if.sink   in_i,
  alist_rsp_if.source out_o
);
  import alist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  alist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alist_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (in_i.req),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_o.rsp)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("Request accepted while another is in flight.");

  a_found_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.rsp.status != ST_OK) |-> (out_o.rsp.found_index == 4'd0))
    else $error("Nonzero found index on a failed request.");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.rsp.status == ST_FULL) |-> (out_o.rsp.length == 5'(CAPACITY)))
    else $error("List full reported below capacity.");
`endif

endmodule

[rtl/alist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/alist_ctrl.sv]
// Controller of the array list engine: sequences find, insert and delete over the
// datapath and owns both handshakes. Depends on alist_pkg.
module alist_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  alist_pkg::sts_t sts_i,
  output alist_pkg::cmd_t cmd_o
);
  import alist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CHK,
    S_INS_CHK,
    S_INS_RD,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    found_q, found_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_d = ST_OK;
        found_d  = 1'b0;
        unique case (sts_i.op)
          OP_FIND: begin
            if (sts_i.cnt_zero) begin
              status_d = ST_NOTFOUND;
              state_d  = S_FINISH;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_init = IDX_ZERO;
              state_d        = S_FIND_RD;
            end
          end
          OP_INSERT: begin
            if (sts_i.full) begin
              status_d = ST_FULL;
              state_d  = S_FINISH;
            end else if (sts_i.pos_zero || !sts_i.ins_pos_ok) begin
              status_d = ST_BADPOS;
              state_d  = S_FINISH;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_init = IDX_COUNT;
              state_d        = S_INS_CHK;
            end
          end
          OP_DELETE: begin
            if (sts_i.pos_zero || !sts_i.del_pos_ok) begin
              status_d = ST_BADPOS;
              state_d  = S_FINISH;
            end else begin
              cmd_o.idx_load = 1'b1;
              cmd_o.idx_init = IDX_POS;
              state_d        = S_DEL_CHK;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_FIND_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_IDX;
        state_d      = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (sts_i.match) begin
          found_d = 1'b1;
          state_d = S_FINISH;
        end else if (sts_i.idx_next_eq_cnt) begin
          status_d = ST_NOTFOUND;
          state_d  = S_FINISH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_FIND_RD;
        end
      end
      S_INS_CHK: begin
        if (sts_i.idx_eq_pos_m1) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_val  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_FINISH;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_DEC;
        state_d      = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (sts_i.idx_next_eq_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end else begin
          state_d = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_INC;
        state_d      = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_DEL_CHK;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = status_q;
          cmd_o.res_found  = found_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/alist_dp.sv]
// Datapath of the array list engine: request register, entry count, index counter,
// entry RAM and response register. Depends on alist_pkg and alist_ram.
module alist_dp #(
  parameter int CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  alist_pkg::req_t req_i,
  input  alist_pkg::cmd_t cmd_i,
  output alist_pkg::sts_t sts_o,
  output alist_pkg::rsp_t rsp_o
);
  import alist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = ((CW > 5) ? CW : 5) + 1;

  op_e               op_q;
  logic signed [31:0] val_q;
  logic [4:0]        pos_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     idx_q;
  rsp_t              rsp_q;

  logic [EW-1:0] idx_ext, pos_ext, cnt_ext, pos_m1;
  logic [CW-1:0] idx_m1, idx_p1;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata, wdata;

  assign idx_ext = EW'(idx_q);
  assign pos_ext = EW'(pos_q);
  assign cnt_ext = EW'(cnt_q);
  assign pos_m1  = pos_ext - EW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_DEC:  raddr = idx_m1[AW-1:0];
      RA_INC:  raddr = idx_p1[AW-1:0];
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  assign wdata = cmd_i.wr_val ? val_q : rdata;

  alist_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q  <= op_e'(req_i.op);
      val_q <= req_i.item_value;
      pos_q <= req_i.position;
    end
    if (cmd_i.idx_load) begin
      unique case (cmd_i.idx_init)
        IDX_COUNT: idx_q <= cnt_q;
        IDX_POS:   idx_q <= pos_m1[CW-1:0];
        default:   idx_q <= '0;
      endcase
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_p1;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.res_load) begin
      rsp_q.status      <= cmd_i.res_status;
      rsp_q.found_index <= cmd_i.res_found ? idx_ext[3:0] : 4'd0;
      rsp_q.length      <= cnt_ext[4:0];
    end
  end

  assign sts_o.op              = op_q;
  assign sts_o.cnt_zero        = (cnt_q == '0);
  assign sts_o.full            = (cnt_q == CW'(CAPACITY));
  assign sts_o.pos_zero        = (pos_q == '0);
  assign sts_o.ins_pos_ok      = (pos_ext <= cnt_ext + EW'(1));
  assign sts_o.del_pos_ok      = (pos_ext <= cnt_ext);
  assign sts_o.idx_next_eq_cnt = ((idx_ext + EW'(1)) == cnt_ext);
  assign sts_o.idx_eq_pos_m1   = (idx_ext == pos_m1);
  assign sts_o.match           = (rdata == val_q);

  assign rsp_o = rsp_q;

endmodule
